// ===== sv/rps_pkg.sv =====
// shared types, codes and constants of the radiation pressure scalar stream
package rps_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int EXP_W           = 13;

    localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    // exponent of the lowest significand bit of a subnormal double
    localparam logic signed [EXP_W-1:0] LSB_EXP_MIN = -13'sd1074;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UNPACK,
        S_ENORM,
        S_DIVLD,
        S_DIV,
        S_QRND,
        S_QNORM,
        S_SQLOAD,
        S_SQRT,
        S_SRND,
        S_MUL,
        S_MRND,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UNPACK,
        OP_NORM,
        OP_DIVLD,
        OP_DIV,
        OP_QRND,
        OP_SQLOAD,
        OP_SQRT,
        OP_SRND,
        OP_MUL,
        OP_MRND,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic cell_ok;
        logic e_zero;
        logic m_zero;
        logic norm_done;
        logic div_done;
        logic sqrt_done;
        logic mul_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [63:0] scalar_bits;
        logic        cell_valid;
        logic        pass_done;
        logic [63:0] min_energy_bits;
        logic [63:0] max_energy_bits;
        logic [63:0] min_scalar_bits;
        logic [63:0] max_scalar_bits;
        logic [31:0] invalid_count;
        logic        pass_ok;
    } t_result;

endpackage

// ===== sv/rps_ifs.sv =====
// request, result and floor channels of the radiation pressure scalar stream
interface rps_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] energy_bits;
    logic        last_cell;
    modport source (output valid, output energy_bits, output last_cell, input ready);
    modport sink   (input valid, input energy_bits, input last_cell, output ready);
endinterface

interface rps_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] scalar_bits;
    logic        cell_valid;
    logic        pass_done;
    logic [63:0] min_energy_bits;
    logic [63:0] max_energy_bits;
    logic [63:0] min_scalar_bits;
    logic [63:0] max_scalar_bits;
    logic [31:0] invalid_count;
    logic        pass_ok;
    modport source (
        output valid, input ready, output scalar_bits, output cell_valid, output pass_done,
        output min_energy_bits, output max_energy_bits, output min_scalar_bits,
        output max_scalar_bits, output invalid_count, output pass_ok
    );
    modport sink (
        input valid, output ready, input scalar_bits, input cell_valid, input pass_done,
        input min_energy_bits, input max_energy_bits, input min_scalar_bits,
        input max_scalar_bits, input invalid_count, input pass_ok
    );
endinterface

interface rps_cfg_if;
    logic        valid;
    logic        ready;
    logic [62:0] energy_floor;
    modport source (output valid, output energy_floor, input ready);
    modport sink   (input valid, input energy_floor, output ready);
endinterface

// ===== sv/radiation_pressure_scalar_stream.sv =====
// radiation pressure scalar stream: (ug/3)^(3/4) per cell with running statistics
// One cell at a time: a cell is taken, Ug/3 is formed by long division by three
// (eight quotient bits a cycle), then two correctly rounded square roots run
// by digit recurrence at one root bit a cycle, and the significand product is
// built from four 27x27 partial products. On a normal cell the time from
// request to result is set almost wholly by the two 54-step root loops; a
// valid zero or an invalid cell goes from unpack straight to finish. A
// subnormal energy, or a quotient in the subnormal range, is normalised by
// shifting out its leading zeros one at a time (at most 52 each time). Results
// sit in an output register, so the next request is taken while the previous
// result waits. The floor register may be written at any time the block is idle.
module radiation_pressure_scalar_stream import rps_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rps_in_if.sink     i_in,
    rps_out_if.source  o_out,
    rps_cfg_if.sink    i_cfg
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_res;
    logic    w_in_ready;
    logic    w_out_valid;

    // floor writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    rps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    rps_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_energy_bits  (i_in.energy_bits),
        .i_last_cell    (i_in.last_cell),
        .i_cfg_we       (i_cfg.valid),
        .i_energy_floor (i_cfg.energy_floor),
        .i_out_ready    (o_out.ready),
        .o_sts          (w_sts),
        .o_out_valid    (w_out_valid),
        .o_res          (w_res)
    );

    // result register fields onto the output channel
    assign o_out.valid           = w_out_valid;
    assign o_out.scalar_bits     = w_res.scalar_bits;
    assign o_out.cell_valid      = w_res.cell_valid;
    assign o_out.pass_done       = w_res.pass_done;
    assign o_out.min_energy_bits = w_res.min_energy_bits;
    assign o_out.max_energy_bits = w_res.max_energy_bits;
    assign o_out.min_scalar_bits = w_res.min_scalar_bits;
    assign o_out.max_scalar_bits = w_res.max_scalar_bits;
    assign o_out.invalid_count   = w_res.invalid_count;
    assign o_out.pass_ok         = w_res.pass_ok;

endmodule

// ===== sv/rps_ctrl.sv =====
// sequencing state machine of the radiation pressure scalar stream
module rps_ctrl import rps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_second <= 1'b0;
            end else if (r_state == S_SRND) begin
                r_second <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UNPACK;
            S_UNPACK: begin
                if (!i_sts.cell_ok || i_sts.e_zero) n_state = S_FINISH;
                else                                n_state = S_ENORM;
            end
            S_ENORM:  if (i_sts.norm_done) n_state = S_DIVLD;
            S_DIVLD:  n_state = S_DIV;
            S_DIV:    if (i_sts.div_done) n_state = S_QRND;
            S_QRND:   n_state = S_QNORM;
            S_QNORM: begin
                if (i_sts.m_zero)         n_state = S_FINISH;
                else if (i_sts.norm_done) n_state = S_SQLOAD;
            end
            S_SQLOAD: n_state = S_SQRT;
            S_SQRT:   if (i_sts.sqrt_done) n_state = S_SRND;
            S_SRND:   n_state = r_second ? S_MUL : S_SQLOAD;
            S_MUL:    if (i_sts.mul_done) n_state = S_MRND;
            S_MRND:   n_state = S_FINISH;
            S_FINISH: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_UNPACK: o_cmd.op = OP_UNPACK;
            S_ENORM:  o_cmd.op = OP_NORM;
            S_DIVLD:  o_cmd.op = OP_DIVLD;
            S_DIV:    o_cmd.op = OP_DIV;
            S_QRND:   o_cmd.op = OP_QRND;
            S_QNORM:  o_cmd.op = OP_NORM;
            S_SQLOAD: o_cmd.op = OP_SQLOAD;
            S_SQRT:   o_cmd.op = OP_SQRT;
            S_SRND:   o_cmd.op = OP_SRND;
            S_MUL:    o_cmd.op = OP_MUL;
            S_MRND:   o_cmd.op = OP_MRND;
            S_FINISH: if (i_sts.out_free) o_cmd.op = OP_FINISH;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/rps_dp.sv =====
// datapath: unpack, divide by three, two square roots, product, running statistics
module rps_dp import rps_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_energy_bits,
    input  logic        i_last_cell,
    input  logic        i_cfg_we,
    input  logic [62:0] i_energy_floor,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output t_result     o_res
);

    function automatic logic f64_lt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (a[62:0] == 63'd0 && b[62:0] == 63'd0) res = 1'b0;
        else if (a[63] != b[63])                 res = a[63];
        else if (!a[63])                         res = a[62:0] < b[62:0];
        else                                     res = a[62:0] > b[62:0];
        return res;
    endfunction

    logic [62:0]             r_floor;
    logic [63:0]             r_e;
    logic                    r_last;
    logic                    r_valid;
    logic [53:0]             r_m;
    logic signed [EXP_W-1:0] r_x;
    logic [55:0]             r_n;
    logic [55:0]             r_q;
    logic [1:0]              r_r;
    logic [53:0]             r_rad;
    logic [53:0]             r_root;
    logic [57:0]             r_rem;
    logic signed [EXP_W-1:0] r_k;
    logic [52:0]             r_am;
    logic signed [EXP_W-1:0] r_ae;
    logic [53:0]             r_pp;
    logic [105:0]            r_acc;
    logic [63:0]             r_s;
    logic [5:0]              r_cnt;
    logic [63:0]             r_min_e, r_max_e, r_min_s, r_max_s;
    logic [COUNT_WIDTH-1:0]  r_bad;
    logic                    r_ov;
    t_result                 r_res;

    // cell check
    logic w_cell_ok;
    assign w_cell_ok = (r_e[62:52] != 11'h7FF) && (r_floor[62:52] != 11'h7FF)
                       && !f64_lt(r_e, {1'b0, r_floor});

    // divide by three, eight quotient bits a cycle
    logic [1:0] w_dr;
    logic [7:0] w_dq;
    always_comb begin
        logic [2:0] t;
        w_dr = r_r;
        for (int i = 0; i < 8; i++) begin
            t = {w_dr, r_n[55-i]};
            if (t >= 3'd3) begin
                w_dq[7-i] = 1'b1;
                t         = t - 3'd3;
            end else begin
                w_dq[7-i] = 1'b0;
            end
            w_dr = t[1:0];
        end
    end

    // rounding of the quotient, with denormalisation below the subnormal limit
    logic [53:0]             w_qm;
    logic signed [EXP_W-1:0] w_qx;
    always_comb begin
        logic [54:0]             x, sh, lmask;
        logic signed [EXP_W-1:0] l, dfull;
        logic [5:0]              d;
        logic                    lost, inc;
        if (r_q[54]) begin
            x = {r_q[54:2], r_q[1], r_q[0] | (r_r != 2'd0)};
            l = r_x - 13'sd1;
        end else begin
            x = {r_q[53:1], r_q[0], r_r != 2'd0};
            l = r_x - 13'sd2;
        end
        dfull = LSB_EXP_MIN - l;
        if (l >= LSB_EXP_MIN)     d = 6'd0;
        else if (dfull > 13'sd55) d = 6'd55;
        else                      d = dfull[5:0];
        sh    = x >> d;
        lmask = (55'd1 << d) - 55'd1;
        lost  = |(x & lmask);
        inc   = sh[1] & (sh[0] | lost | sh[2]);
        w_qm  = {1'b0, sh[54:2]} + {53'd0, inc};
        w_qx  = (l < LSB_EXP_MIN) ? LSB_EXP_MIN : l;
    end

    // one root digit a cycle
    logic [57:0] w_remn, w_trial;
    assign w_remn  = {r_rem[55:0], r_rad[53:52]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // root rounding
    logic [53:0]             w_rsum;
    logic signed [EXP_W-1:0] w_rx;
    assign w_rsum = {1'b0, r_root[53:1]}
                    + {53'd0, r_root[0] & ((r_rem != 58'd0) | r_root[1])};
    assign w_rx   = (r_k >>> 1) - 13'sd26;

    // partial products of the significand product
    logic [26:0] w_opa, w_opb;
    assign w_opa = r_cnt[1] ? {1'b0, r_am[52:27]} : r_am[26:0];
    assign w_opb = r_cnt[0] ? {1'b0, r_m[52:27]}  : r_m[26:0];

    // product rounding and packing
    logic [63:0] w_sbits;
    always_comb begin
        logic [52:0]             mant;
        logic                    rnd, st;
        logic [53:0]             sum;
        logic signed [EXP_W-1:0] bexp;
        bexp = r_ae + r_x + 13'sd1127;
        if (r_acc[105]) begin
            mant = r_acc[105:53];
            rnd  = r_acc[52];
            st   = |r_acc[51:0];
            bexp = bexp + 13'sd1;
        end else begin
            mant = r_acc[104:52];
            rnd  = r_acc[51];
            st   = |r_acc[50:0];
        end
        sum = {1'b0, mant} + {53'd0, rnd & (st | mant[0])};
        if (sum[53]) begin
            bexp = bexp + 13'sd1;
            w_sbits = {1'b0, bexp[10:0], sum[52:1]};
        end else begin
            w_sbits = {1'b0, bexp[10:0], sum[51:0]};
        end
    end

    // running statistics for the finishing cell
    logic [63:0]            n_min_e, n_max_e, n_min_s, n_max_s;
    logic [COUNT_WIDTH-1:0] n_bad;
    logic [63:0]            w_bad_ext;
    always_comb begin
        n_min_e = r_min_e;
        n_max_e = r_max_e;
        n_min_s = r_min_s;
        n_max_s = r_max_s;
        n_bad   = r_bad;
        if (r_valid) begin
            if (f64_lt(r_e, r_min_e)) n_min_e = r_e;
            if (f64_lt(r_max_e, r_e)) n_max_e = r_e;
            if (f64_lt(r_s, r_min_s)) n_min_s = r_s;
            if (f64_lt(r_max_s, r_s)) n_max_s = r_s;
        end else if (r_bad != {COUNT_WIDTH{1'b1}}) begin
            n_bad = r_bad + 1'b1;
        end
    end
    assign w_bad_ext = 64'(n_bad);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
            r_min_e <= POS_INF_BITS;
            r_max_e <= NEG_INF_BITS;
            r_min_s <= POS_INF_BITS;
            r_max_s <= NEG_INF_BITS;
            r_bad   <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) r_floor <= i_energy_floor;
            if (i_cmd.op == OP_DIV || i_cmd.op == OP_SQRT || i_cmd.op == OP_MUL) begin
                r_cnt <= r_cnt + 6'd1;
            end else begin
                r_cnt <= '0;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_ov <= 1'b1;
                if (r_last) begin
                    r_min_e <= POS_INF_BITS;
                    r_max_e <= NEG_INF_BITS;
                    r_min_s <= POS_INF_BITS;
                    r_max_s <= NEG_INF_BITS;
                    r_bad   <= '0;
                end else begin
                    r_min_e <= n_min_e;
                    r_max_e <= n_max_e;
                    r_min_s <= n_min_s;
                    r_max_s <= n_max_s;
                    r_bad   <= n_bad;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_e    <= i_energy_bits;
                r_last <= i_last_cell;
            end
            OP_UNPACK: begin
                r_valid <= w_cell_ok;
                r_s     <= '0;
                if (r_e[62:52] == 11'd0) begin
                    r_m <= {2'b00, r_e[51:0]};
                    r_x <= LSB_EXP_MIN;
                end else begin
                    r_m <= {2'b01, r_e[51:0]};
                    r_x <= $signed({2'b00, r_e[62:52]}) - 13'sd1075;
                end
            end
            OP_NORM: begin
                if (r_m[53]) begin
                    r_m <= {1'b0, r_m[53:1]};
                    r_x <= r_x + 13'sd1;
                end else if (!r_m[52] && r_m != 54'd0) begin
                    r_m <= {r_m[52:0], 1'b0};
                    r_x <= r_x - 13'sd1;
                end
            end
            OP_DIVLD: begin
                r_n <= {r_m[52:0], 3'b000};
                r_r <= 2'd0;
            end
            OP_DIV: begin
                r_n <= {r_n[47:0], 8'd0};
                r_q <= {r_q[47:0], w_dq};
                r_r <= w_dr;
            end
            OP_QRND: begin
                r_m <= w_qm;
                r_x <= w_qx;
            end
            OP_SQLOAD: begin
                r_am   <= r_m[52:0];
                r_ae   <= r_x;
                r_rem  <= '0;
                r_root <= '0;
                if (r_x[0]) begin
                    r_rad <= {r_m[52:0], 1'b0};
                    r_k   <= r_x - 13'sd1;
                end else begin
                    r_rad <= {1'b0, r_m[52:0]};
                    r_k   <= r_x;
                end
            end
            OP_SQRT: begin
                r_rad <= {r_rad[51:0], 2'b00};
                if (w_remn >= w_trial) begin
                    r_rem  <= w_remn - w_trial;
                    r_root <= {r_root[52:0], 1'b1};
                end else begin
                    r_rem  <= w_remn;
                    r_root <= {r_root[52:0], 1'b0};
                end
            end
            OP_SRND: begin
                if (w_rsum[53]) begin
                    r_m <= {1'b0, w_rsum[53:1]};
                    r_x <= w_rx + 13'sd1;
                end else begin
                    r_m <= w_rsum;
                    r_x <= w_rx;
                end
            end
            OP_MUL: begin
                r_pp <= w_opa * w_opb;
                unique case (r_cnt[2:0])
                    3'd0:      r_acc <= '0;
                    3'd1:      r_acc <= r_acc + 106'(r_pp);
                    3'd2,
                    3'd3:      r_acc <= r_acc + (106'(r_pp) << 27);
                    default:   r_acc <= r_acc + (106'(r_pp) << 54);
                endcase
            end
            OP_MRND: r_s <= w_sbits;
            OP_FINISH: begin
                r_res.scalar_bits     <= r_s;
                r_res.cell_valid      <= r_valid;
                r_res.pass_done       <= r_last;
                r_res.min_energy_bits <= n_min_e;
                r_res.max_energy_bits <= n_max_e;
                r_res.min_scalar_bits <= n_min_s;
                r_res.max_scalar_bits <= n_max_s;
                r_res.invalid_count   <= w_bad_ext[31:0];
                r_res.pass_ok         <= r_last && (n_bad == '0);
            end
            default: ;
        endcase
    end

    assign o_sts.cell_ok   = w_cell_ok;
    assign o_sts.e_zero    = (r_e[62:0] == 63'd0);
    assign o_sts.m_zero    = (r_m == 54'd0);
    assign o_sts.norm_done = (r_m[53:52] == 2'b01);
    assign o_sts.div_done  = (r_cnt == 6'd6);
    assign o_sts.sqrt_done = (r_cnt == 6'd53);
    assign o_sts.mul_done  = (r_cnt == 6'd4);
    assign o_sts.out_free  = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_res       = r_res;

endmodule

// ===== tb/sv/radiation_pressure_scalar_stream_test.sv =====
// self-checking testbench of the radiation pressure scalar stream
module radiation_pressure_scalar_stream_test import rps_pkg::*;;

    // settling time after a drain, enough for a normal cell plus up to two
    // normalisation passes
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_CELLS  = 1700;

    logic i_clk;
    logic i_rst_n;

    rps_in_if  in_ch ();
    rps_out_if out_ch ();
    rps_cfg_if cfg_ch ();

    radiation_pressure_scalar_stream i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    typedef struct {
        logic [63:0] energy;
        logic        last;
    } t_cell;

    // cells waiting for the driver, and scalar results still owed by the block
    t_cell   cell_q[$];
    t_result scalar_expect_q[$];

    // predictor copy of the floor register and the running pass statistics
    logic [62:0] floor_bits;
    logic [63:0] lo_energy, hi_energy, lo_scalar, hi_scalar;
    logic [COUNT_WIDTH_DEF-1:0] bad_count;

    int error_count;
    int cells_taken, results_seen, passes_seen, invalid_seen;
    int sent_count, taken_count, cfg_count;
    int gap_left, stall_left;
    bit hold_sender;   // sender waits until the block has drained
    bit quiet_mode;    // no idling on either side

    always #5 i_clk = ~i_clk;

    function automatic bit is_finite(logic [63:0] b);
        return b[62:52] != 11'h7FF;
    endfunction

    // expected result of one cell; updates the running statistics
    function automatic t_result scalar_predict(logic [63:0] e, logic last);
        t_result r;
        real     v, q, r2, r4, s;
        logic [63:0] sb;
        bit      ok;
        ok = is_finite(e) && is_finite({1'b0, floor_bits}) &&
             !($bitstoreal(e) < $bitstoreal({1'b0, floor_bits}));
        sb = '0;
        if (ok) begin
            v  = $bitstoreal(e);
            q  = v / 3.0;
            // square roots are correctly rounded, so the library root matches
            r2 = $sqrt(q);
            r4 = $sqrt(r2);
            s  = r2 * r4;
            sb = $realtobits(s);
            if (v < $bitstoreal(lo_energy)) lo_energy = e;
            if ($bitstoreal(hi_energy) < v) hi_energy = e;
            if (s < $bitstoreal(lo_scalar)) lo_scalar = sb;
            if ($bitstoreal(hi_scalar) < s) hi_scalar = sb;
        end else if (bad_count != '1) begin
            bad_count = bad_count + 1'b1;
        end
        r.scalar_bits     = sb;
        r.cell_valid      = ok;
        r.pass_done       = last;
        r.min_energy_bits = lo_energy;
        r.max_energy_bits = hi_energy;
        r.min_scalar_bits = lo_scalar;
        r.max_scalar_bits = hi_scalar;
        r.invalid_count   = bad_count[31:0];
        r.pass_ok         = last && (bad_count == 0);
        // pass over: statistics go back to their reset values
        if (last) begin
            lo_energy = POS_INF_BITS;
            hi_energy = NEG_INF_BITS;
            lo_scalar = POS_INF_BITS;
            hi_scalar = NEG_INF_BITS;
            bad_count = '0;
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int next_gap();
        int p;
        p = $urandom_range(99);
        if (quiet_mode || p < 60) return 0;
        if (p < 94) return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // request acceptance, prediction and checking, all at the rising edge
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                floor_bits = cfg_ch.energy_floor;
                cfg_count++;
            end
            if (in_ch.valid && in_ch.ready) begin
                scalar_expect_q = {scalar_expect_q,
                                   scalar_predict(in_ch.energy_bits, in_ch.last_cell)};
                taken_count++;
                cells_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (scalar_expect_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, scalar %h", $time, out_ch.scalar_bits);
                end else begin
                    exp_r = scalar_expect_q.pop_front();
                    if (!out_ch.cell_valid) invalid_seen++;
                    if (out_ch.pass_done) passes_seen++;
                    check_field("scalar_bits", exp_r.scalar_bits, out_ch.scalar_bits);
                    check_field("cell_valid", 64'(exp_r.cell_valid), 64'(out_ch.cell_valid));
                    check_field("pass_done", 64'(exp_r.pass_done), 64'(out_ch.pass_done));
                    check_field("min_energy_bits", exp_r.min_energy_bits,
                                out_ch.min_energy_bits);
                    check_field("max_energy_bits", exp_r.max_energy_bits,
                                out_ch.max_energy_bits);
                    check_field("min_scalar_bits", exp_r.min_scalar_bits,
                                out_ch.min_scalar_bits);
                    check_field("max_scalar_bits", exp_r.max_scalar_bits,
                                out_ch.max_scalar_bits);
                    check_field("invalid_count", 64'(exp_r.invalid_count),
                                64'(out_ch.invalid_count));
                    check_field("pass_ok", 64'(exp_r.pass_ok), 64'(out_ch.pass_ok));
                end
            end
        end
    end

    // request driver: a new cell once the previous one is taken and the gap has run out
    always @(negedge i_clk) begin
        t_cell c;
        if (i_rst_n && (!in_ch.valid || taken_count == sent_count)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (!hold_sender && cell_q.size() != 0) begin
                c = cell_q.pop_front();
                in_ch.energy_bits <= c.energy;
                in_ch.last_cell   <= c.last;
                in_ch.valid       <= 1'b1;
                sent_count++;
                gap_left = next_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(7) == 0) stall_left = next_gap();
            end
        end
    end

    task automatic add_cell(logic [63:0] e, logic last);
        t_cell c;
        c.energy = e;
        c.last   = last;
        cell_q   = {cell_q, c};
    endtask

    // wait until the block has nothing in flight, then let it settle
    task automatic drain();
        while (cell_q.size() != 0 || scalar_expect_q.size() != 0 ||
               taken_count != sent_count)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_floor(logic [62:0] f);
        int n;
        n = cfg_count;
        @(negedge i_clk);
        cfg_ch.energy_floor <= f;
        cfg_ch.valid        <= 1'b1;
        while (cfg_count == n) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random energy: raw patterns, values near one and near the floor, subnormals, zeros and specials
    function automatic logic [63:0] random_energy();
        logic [63:0] e;
        int p;
        e = {$urandom, $urandom};
        p = $urandom_range(99);
        if (p < 30) begin
            e[63]    = 1'b0;
            e[62:52] = 11'(1023 + $urandom_range(80) - 40);
        end else if (p < 45) begin
            e[62:52] = 11'(floor_bits[62:52] + $urandom_range(2) - 1);
            e[63]    = ($urandom_range(9) == 0);
        end else if (p < 55) begin
            e[62:52] = 11'd0;
            e[63]    = ($urandom_range(4) == 0);
            if ($urandom_range(1)) e[51:0] = e[51:0] >> $urandom_range(51);
        end else if (p < 62) begin
            e[62:52] = 11'h7FF;
            if ($urandom_range(1)) e[51:0] = '0;
        end else if (p < 65) begin
            e[62:0] = '0;
        end
        return e;
    endfunction

    task automatic random_passes(int n);
        for (int i = 0; i < n; i++)
            add_cell(random_energy(), $urandom_range(19) == 0);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.energy_bits = '0;
        in_ch.last_cell = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.energy_floor = '0;
        floor_bits = '0;
        lo_energy = POS_INF_BITS;
        hi_energy = NEG_INF_BITS;
        lo_scalar = POS_INF_BITS;
        hi_scalar = NEG_INF_BITS;
        bad_count = '0;
        hold_sender = 1'b0;
        quiet_mode = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed cells at the reset floor of zero
        add_cell(64'h0000_0000_0000_0000, 1'b0);   // positive zero
        add_cell(64'h8000_0000_0000_0000, 1'b0);   // negative zero is valid
        add_cell(64'h0000_0000_0000_0001, 1'b0);   // smallest subnormal
        add_cell(64'h000F_FFFF_FFFF_FFFF, 1'b0);   // largest subnormal
        add_cell(64'h0010_0000_0000_0000, 1'b0);   // smallest normal
        add_cell(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);   // largest finite
        add_cell(64'h3FF0_0000_0000_0000, 1'b0);   // one
        add_cell(64'h4008_0000_0000_0000, 1'b1);   // three, clean pass ends
        add_cell(64'h7FF0_0000_0000_0000, 1'b0);   // +inf
        add_cell(64'hFFF0_0000_0000_0000, 1'b0);   // -inf
        add_cell(64'h7FF8_0000_0000_0000, 1'b0);   // quiet nan
        add_cell(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);   // all-invalid pass
        add_cell(64'hBFF0_0000_0000_0000, 1'b0);   // negative
        add_cell(64'h4059_0000_0000_0000, 1'b1);   // mixed pass ends
        drain();

        // floor of one: small and negative cells fall below it
        write_floor(63'h3FF0_0000_0000_0000);
        add_cell(64'h3FEF_FFFF_FFFF_FFFF, 1'b0);
        add_cell(64'h3FF0_0000_0000_0000, 1'b0);
        add_cell(64'h8000_0000_0000_0000, 1'b0);
        add_cell(64'h4010_0000_0000_0000, 1'b1);
        random_passes(300);
        // hold the sender until every result is back
        hold_sender = 1'b1;
        while (scalar_expect_q.size() != 0) @(negedge i_clk);
        hold_sender = 1'b0;
        drain();

        // floor at the largest finite value
        write_floor(63'h7FEF_FFFF_FFFF_FFFF);
        add_cell(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        add_cell(64'h7FEF_FFFF_FFFF_FFFE, 1'b1);
        random_passes(150);
        drain();

        // infinite and nan floors: every cell is invalid
        write_floor(63'h7FF0_0000_0000_0000);
        add_cell(64'h3FF0_0000_0000_0000, 1'b1);
        random_passes(100);
        drain();
        write_floor(63'h7FFF_FFFF_FFFF_FFFF);
        random_passes(100);
        drain();

        // smallest subnormal floor, back-to-back with no idling
        write_floor(63'h0000_0000_0000_0001);
        quiet_mode = 1'b1;
        random_passes(250);
        drain();
        quiet_mode = 1'b0;

        // random floors around the useful range, then back to zero
        for (int k = 0; k < 4; k++) begin
            write_floor({1'b0, 11'd1023 + 11'($urandom_range(40)) - 11'd20,
                         51'({$urandom, $urandom})});
            random_passes(150);
            drain();
        end
        write_floor('0);
        random_passes(200);
        drain();

        $display("covered %0d cells in %0d passes, %0d invalid, %0d results checked",
                 cells_taken, passes_seen, invalid_seen, results_seen);
        $display("floor written %0d times, zero to nan patterns included", cfg_count);
        if (error_count == 0 && scalar_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #40000000;
        $display("timeout with %0d results outstanding", scalar_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
